FILE: sv/fsp_pkg.sv
// Package for the five-stage pipeline: opcodes, item kinds and the decoded instruction type.
// No dependencies.
package fsp_pkg;
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_ADDI = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_BEQ  = 3'd4;
    localparam logic [2:0] OP_LW   = 3'd5;
    localparam logic [2:0] OP_SW   = 3'd6;
    localparam logic [2:0] OP_HALT = 3'd7;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [1:0] CFG_MULT = 2'd0;
    localparam logic [1:0] CFG_ALU  = 2'd1;
    localparam logic [1:0] CFG_MEM  = 2'd2;

    localparam int REG_NUM    = 32;
    localparam int IMEM_WORDS = 512;
    localparam int DMEM_WORDS = 512;

    typedef struct packed {
        logic [2:0]  op;
        logic [4:0]  rd;
        logic [4:0]  ra;
        logic [4:0]  rb;
        logic [15:0] imm;
    } t_instr;

    function automatic logic writes_reg(input logic [2:0] op);
        return op == OP_ADD || op == OP_ADDI || op == OP_SUB || op == OP_MUL || op == OP_LW;
    endfunction
endpackage

FILE: sv/five_stage_pipeline_interlocked.sv
// Five-stage in-order pipeline model: top level with all stage state and the result register.
// Depends on fsp_pkg.
//
// Usage: s_axis carries items. tuser = kind (0 loads an instruction word into the
// instruction store, 1 advances the pipeline one tick). tdata = {imm, src_b, src_a,
// dest_reg, op, load_addr} from the high bit down. Every accepted item gives exactly one
// result on m_axis: tdata = {halted, pc, store_value, store_addr, store_valid,
// wb_value, wb_reg, wb_valid} from the high bit down.
// The result register is loaded when the item is accepted; one item is taken each cycle
// while no clearing sweep runs and the receiver takes results. The whole tick (WB, MEM,
// EX, ID, IF) is one pass of logic between the stage registers and the result register.
// The instruction and data stores are read through registers that follow the next pc,
// the next branch target and the next data address every cycle, with a same-cycle write
// passed through. While the receiver stalls, a result waits in the output register and
// a new item is taken only if that register empties in the same cycle.
// Reset clears the pipeline latches and pc, sets wait counters and latencies to 1; the
// register file and data store are cleared by a sweep during which no item is taken.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) are taken at any time.
module five_stage_pipeline_interlocked #(
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // load_addr, op, dest_reg, src_a, src_b, imm
    input  logic        s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,  // wb_valid, wb_reg, wb_value, store_valid,
                                       // store_addr, store_value, pc, halted
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import fsp_pkg::*;

    localparam int IAW = $clog2(IMEM_WORDS);
    localparam int DAW = $clog2(DMEM_WORDS);
    localparam int DW  = DATA_WIDTH;

    // stores
    t_instr        r_imem [IMEM_WORDS];
    logic [DW-1:0] r_rf   [REG_NUM];
    logic [DW-1:0] r_dmem [DMEM_WORDS];

    logic [7:0] r_mult, r_alu, r_mem;
    logic [IAW-1:0] r_pc, n_pc;
    logic r_bw, n_bw, r_halt, n_halt;
    logic [7:0] r_fw, n_fw, r_ew, n_ew, r_mw, n_mw;
    logic r_fd_v, n_fd_v;
    t_instr r_fd, n_fd;
    logic r_de_v, n_de_v;
    logic [2:0] r_de_op, n_de_op;
    logic [4:0] r_de_dest, n_de_dest;
    logic [DW-1:0] r_de_x, n_de_x, r_de_y, n_de_y;
    logic [15:0] r_de_imm, n_de_imm;
    logic r_em_v, n_em_v;
    logic [2:0] r_em_op, n_em_op;
    logic [4:0] r_em_dest, n_em_dest;
    logic [DW-1:0] r_em_val, n_em_val, r_em_data, n_em_data;
    logic r_mw_v, n_mw_v;
    logic [2:0] r_mw_op, n_mw_op;
    logic [4:0] r_mw_dest, n_mw_dest;
    logic [DW-1:0] r_mw_val, n_mw_val;

    logic r_clr, r_ov;
    logic [DAW:0] r_ccnt;
    logic [95:0] r_out, n_out;

    logic acc, tick, wb_we, st_we;
    logic [DAW-1:0] st_a;
    logic [4:0] wb_r;
    logic [DW-1:0] wb_v, st_v;

    logic [7:0] lat_m, lat_a, lat_f;

    // store read ports
    t_instr r_if_seq, r_if_br, im_wd;
    logic [IAW-1:0] pc_nx, tgt_nx, im_wa;
    logic [15:0] imm_nx;
    logic im_we, dm_we;
    logic [DAW-1:0] dm_wa, dm_ra;
    logic [DW-1:0] dm_wd, r_dq;

    function automatic logic busy(input logic [4:0] r, input logic emv, input logic [2:0] emo,
                                  input logic [4:0] emd, input logic mwv,
                                  input logic [2:0] mwo, input logic [4:0] mwd);
        return r != 5'd0 && ((emv && writes_reg(emo) && emd == r) ||
                             (mwv && writes_reg(mwo) && mwd == r));
    endfunction

    assign s_axis_tready = !r_clr && (!r_ov || m_axis_tready);
    assign acc  = s_axis_tvalid && s_axis_tready;
    assign tick = acc && s_axis_tuser == KIND_TICK && !r_halt;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = r_out;

    assign lat_m = (r_mult == 8'd0) ? 8'd1 : r_mult;
    assign lat_a = (r_alu == 8'd0) ? 8'd1 : r_alu;
    assign lat_f = (r_mem == 8'd0) ? 8'd1 : r_mem;

    // addresses the stage registers will hold after this edge
    assign pc_nx  = tick ? n_pc : r_pc;
    assign imm_nx = tick ? n_de_imm : r_de_imm;
    assign tgt_nx = IAW'(pc_nx + IAW'($signed(imm_nx)));
    assign im_we  = acc && s_axis_tuser == KIND_LOAD;
    assign im_wa  = s_axis_tdata[IAW-1:0];
    assign im_wd  = '{op: s_axis_tdata[11:9], rd: s_axis_tdata[16:12],
                      ra: s_axis_tdata[21:17], rb: s_axis_tdata[26:22],
                      imm: s_axis_tdata[42:27]};
    assign dm_we  = r_clr || (tick && st_we);
    assign dm_wa  = r_clr ? r_ccnt[DAW-1:0] : st_a;
    assign dm_wd  = r_clr ? '0 : st_v;
    assign dm_ra  = tick ? n_em_val[DAW-1:0] : r_em_val[DAW-1:0];

    always_comb begin
        logic [DW-1:0] r;
        logic [7:0] lat;
        logic two, pair, hz, taken;
        logic [IAW-1:0] tgt;
        n_pc = r_pc; n_bw = r_bw; n_halt = r_halt;
        n_fw = r_fw; n_ew = r_ew; n_mw = r_mw;
        n_fd_v = r_fd_v; n_fd = r_fd;
        n_de_v = r_de_v; n_de_op = r_de_op; n_de_dest = r_de_dest;
        n_de_x = r_de_x; n_de_y = r_de_y; n_de_imm = r_de_imm;
        n_em_v = r_em_v; n_em_op = r_em_op; n_em_dest = r_em_dest;
        n_em_val = r_em_val; n_em_data = r_em_data;
        n_mw_v = r_mw_v; n_mw_op = r_mw_op; n_mw_dest = r_mw_dest; n_mw_val = r_mw_val;
        wb_we = 1'b0; wb_r = r_mw_dest; wb_v = r_mw_val;
        st_we = 1'b0; st_a = r_em_val[DAW-1:0]; st_v = r_em_data;
        r = '0; lat = '0; two = 1'b0; pair = 1'b0; hz = 1'b0; taken = 1'b0; tgt = '0;

        // WB
        if (r_mw_v) begin
            if (writes_reg(r_mw_op) && r_mw_dest != 5'd0) wb_we = 1'b1;
            if (r_mw_op == OP_HALT) n_halt = 1'b1;
            n_mw_v = 1'b0;
        end
        // MEM
        if (r_em_v && !n_mw_v) begin
            if (r_em_op == OP_SW || r_em_op == OP_LW) begin
                if (r_mw < lat_f) begin
                    n_mw = r_mw + 8'd1;
                end else begin
                    n_mw = 8'd1;
                    n_mw_op = r_em_op; n_mw_dest = r_em_dest;
                    n_mw_val = (r_em_op == OP_SW) ? '0 : r_dq;
                    if (r_em_op == OP_SW) st_we = 1'b1;
                    n_mw_v = 1'b1; n_em_v = 1'b0;
                end
            end else begin
                n_mw_op = r_em_op; n_mw_dest = r_em_dest; n_mw_val = r_em_val;
                n_mw_v = 1'b1; n_em_v = 1'b0;
            end
        end
        // EX
        if (r_de_v && !n_em_v) begin
            if (r_de_op == OP_HALT) begin
                n_em_op = OP_HALT; n_em_dest = '0; n_em_val = '0; n_em_data = '0;
                n_em_v = 1'b1; n_de_v = 1'b0;
            end else begin
                lat = (r_de_op == OP_MUL) ? lat_m : lat_a;
                if (r_ew < lat) begin
                    n_ew = r_ew + 8'd1;
                end else begin
                    n_ew = 8'd1;
                    case (r_de_op)
                        OP_ADD: r = r_de_x + r_de_y;
                        OP_SUB: r = r_de_x - r_de_y;
                        OP_MUL: r = DW'(r_de_x * r_de_y);
                        OP_BEQ: begin
                            if (r_de_x == r_de_y) begin
                                tgt = IAW'(r_pc + IAW'($signed(r_de_imm)));
                                n_pc = tgt;
                                taken = 1'b1;
                            end
                            n_bw = 1'b0;
                        end
                        default: r = r_de_x + DW'($signed(r_de_imm));
                    endcase
                    n_em_op = r_de_op; n_em_dest = r_de_dest; n_em_val = r;
                    n_em_data = (r_de_op == OP_SW) ? r_de_y : '0;
                    n_em_v = 1'b1; n_de_v = 1'b0;
                end
            end
        end
        // ID
        if (r_fd_v && !n_de_v) begin
            if (r_fd.op == OP_HALT) begin
                n_de_op = OP_HALT; n_de_dest = '0; n_de_x = '0; n_de_y = '0;
                n_de_imm = '0; n_de_v = 1'b1;
            end else begin
                two  = r_fd.op == OP_ADD || r_fd.op == OP_SUB || r_fd.op == OP_MUL;
                pair = r_fd.op == OP_SW || r_fd.op == OP_BEQ;
                hz = busy(r_fd.ra, n_em_v, n_em_op, n_em_dest, n_mw_v, n_mw_op, n_mw_dest)
                  || (two && busy(r_fd.rb, n_em_v, n_em_op, n_em_dest,
                                  n_mw_v, n_mw_op, n_mw_dest))
                  || (pair && busy(r_fd.rd, n_em_v, n_em_op, n_em_dest,
                                   n_mw_v, n_mw_op, n_mw_dest));
                if (!hz) begin
                    // read through a same-tick writeback
                    n_de_op = r_fd.op;
                    n_de_dest = pair ? 5'd0 : r_fd.rd;
                    n_de_x = (r_fd.ra == 5'd0) ? '0 :
                             (wb_we && wb_r == r_fd.ra) ? wb_v : r_rf[r_fd.ra];
                    if (two)
                        n_de_y = (r_fd.rb == 5'd0) ? '0 :
                                 (wb_we && wb_r == r_fd.rb) ? wb_v : r_rf[r_fd.rb];
                    else if (pair)
                        n_de_y = (r_fd.rd == 5'd0) ? '0 :
                                 (wb_we && wb_r == r_fd.rd) ? wb_v : r_rf[r_fd.rd];
                    else
                        n_de_y = '0;
                    n_de_imm = r_fd.imm;
                    n_de_v = 1'b1; n_fd_v = 1'b0;
                    if (r_fd.op == OP_BEQ) n_bw = 1'b1;
                end
            end
        end
        // IF
        if (!n_fd_v && !n_bw) begin
            if (r_fw < lat_f) begin
                n_fw = r_fw + 8'd1;
            end else begin
                n_fw = 8'd1;
                n_fd = taken ? r_if_br : r_if_seq;
                n_fd_v = 1'b1;
                n_pc = IAW'(n_pc + 1'b1);
            end
        end
    end

    // instruction store: words at the next pc and at the next branch target
    always_ff @(posedge i_clk) begin
        if (im_we) r_imem[im_wa] <= im_wd;
        r_if_seq <= (im_we && im_wa == pc_nx) ? im_wd : r_imem[pc_nx];
        r_if_br  <= (im_we && im_wa == tgt_nx) ? im_wd : r_imem[tgt_nx];
    end

    // register file and data store, cleared by the sweep after reset
    always_ff @(posedge i_clk) begin
        if (dm_we) r_dmem[dm_wa] <= dm_wd;
        r_dq <= (dm_we && dm_wa == dm_ra) ? dm_wd : r_dmem[dm_ra];
        if (r_clr) begin
            if (r_ccnt < (DAW+1)'(REG_NUM)) r_rf[r_ccnt[4:0]] <= '0;
        end else if (tick && wb_we) begin
            r_rf[wb_r] <= wb_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= 1'b1; r_ccnt <= '0; r_ov <= 1'b0;
            r_mult <= 8'd1; r_alu <= 8'd1; r_mem <= 8'd1;
            r_pc <= '0; r_bw <= 1'b0; r_halt <= 1'b0;
            r_fw <= 8'd1; r_ew <= 8'd1; r_mw <= 8'd1;
            r_fd_v <= 1'b0; r_de_v <= 1'b0; r_em_v <= 1'b0; r_mw_v <= 1'b0;
            r_de_op <= '0; r_de_dest <= '0; r_de_x <= '0; r_de_y <= '0; r_de_imm <= '0;
            r_em_op <= '0; r_em_dest <= '0; r_em_val <= '0; r_em_data <= '0;
            r_mw_op <= '0; r_mw_dest <= '0; r_mw_val <= '0;
        end else begin
            if (r_clr) begin
                r_ccnt <= r_ccnt + 1'b1;
                if (r_ccnt == (DAW+1)'(DMEM_WORDS - 1)) r_clr <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MULT: r_mult <= i_cfg_data;
                    CFG_ALU:  r_alu  <= i_cfg_data;
                    CFG_MEM:  r_mem  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (acc) r_ov <= 1'b1;
            else if (m_axis_tready) r_ov <= 1'b0;
            if (tick) begin
                r_pc <= n_pc; r_bw <= n_bw; r_halt <= n_halt;
                r_fw <= n_fw; r_ew <= n_ew; r_mw <= n_mw;
                r_fd_v <= n_fd_v; r_de_v <= n_de_v; r_em_v <= n_em_v; r_mw_v <= n_mw_v;
                r_de_op <= n_de_op; r_de_dest <= n_de_dest; r_de_x <= n_de_x;
                r_de_y <= n_de_y; r_de_imm <= n_de_imm;
                r_em_op <= n_em_op; r_em_dest <= n_em_dest; r_em_val <= n_em_val;
                r_em_data <= n_em_data;
                r_mw_op <= n_mw_op; r_mw_dest <= n_mw_dest; r_mw_val <= n_mw_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick) r_fd <= n_fd;
    end

    always_comb begin
        n_out = '0;
        if (tick) begin
            n_out[0]     = wb_we;
            n_out[5:1]   = wb_we ? wb_r : 5'd0;
            n_out[37:6]  = wb_we ? 32'(wb_v) : 32'd0;
            n_out[38]    = st_we;
            n_out[47:39] = st_we ? 9'(st_a) : 9'd0;
            n_out[79:48] = st_we ? 32'(st_v) : 32'd0;
            n_out[88:80] = 9'(n_pc);
            n_out[89]    = n_halt;
        end else begin
            n_out[88:80] = 9'(r_pc);
            n_out[89]    = r_halt;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (acc) r_out <= n_out;
    end
endmodule
